@@ design/swhs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhs_pkg
// Shared types, codes and constants for the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
package swhs_pkg;

	// Frame and field sizes
	localparam int unsigned N_BITS     = 40;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned IDX_W      = 6;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_W       = 8;
	localparam int unsigned OUT_W      = 40;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_PULSE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TMO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_TMO  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_TMO       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD = 3'd4;

	// Register reset values
	localparam logic [15:0] START_PULSE_RST   = 16'd1000;
	localparam logic [7:0]  RELEASE_TMO_RST   = 8'd30;
	localparam logic [7:0]  RESPONSE_TMO_RST  = 8'd90;
	localparam logic [7:0]  BIT_TMO_RST       = 8'd80;
	localparam logic [7:0]  ONE_THRESHOLD_RST = 8'd70;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_CSUM    = 2'd2
	} status_t;

	// Exchange phases, one-hot
	typedef enum logic [6:0] {
		PH_IDLE  = 7'b0000001,
		PH_START = 7'b0000010,
		PH_REL   = 7'b0000100,
		PH_RLOW  = 7'b0001000,
		PH_RHIGH = 7'b0010000,
		PH_BLOW  = 7'b0100000,
		PH_BHIGH = 7'b1000000
	} phase_t;

	// Configuration register set
	typedef struct packed {
		logic [15:0] start_pulse_ticks;
		logic [7:0]  release_timeout;
		logic [7:0]  response_timeout;
		logic [7:0]  bit_timeout;
		logic [7:0]  one_threshold;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic        drive_low;
		logic        busy_res;
		logic        result_valid;
		status_t     status;
		logic [15:0] humidity_tenths;
		logic [15:0] temperature_tenths;
	} result_t;

endpackage

@@ design/swhs_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhs_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module swhs_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [swhs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [swhs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output swhs_pkg::cfg_t                   cfg
);
	import swhs_pkg::*;

	cfg_t cfg_q;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_pulse_ticks <= START_PULSE_RST;
			cfg_q.release_timeout   <= RELEASE_TMO_RST;
			cfg_q.response_timeout  <= RESPONSE_TMO_RST;
			cfg_q.bit_timeout       <= BIT_TMO_RST;
			cfg_q.one_threshold     <= ONE_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_PULSE:   cfg_q.start_pulse_ticks <= cfg_data;
				CFG_RELEASE_TMO:   cfg_q.release_timeout   <= cfg_data[7:0];
				CFG_RESPONSE_TMO:  cfg_q.response_timeout  <= cfg_data[7:0];
				CFG_BIT_TMO:       cfg_q.bit_timeout       <= cfg_data[7:0];
				CFG_ONE_THRESHOLD: cfg_q.one_threshold     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/swhs_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhs_fsm
// Exchange sequencer: one step per sample, phase timing, bit capture,
// checksum and temperature decode.
// ----------------------------------------------------------------------------
module swhs_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              start_req,
	input  logic              line_level,
	input  swhs_pkg::cfg_t    cfg,
	output swhs_pkg::result_t res
);
	import swhs_pkg::*;

	phase_t                phase_q, phase_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d, cnt_inc;
	logic [IDX_W-1:0]      idx_q, idx_d, idx_inc;
	logic [N_BITS-1:0]     frame_q, frame_d;

	logic                  want;
	logic [7:0]            limit;
	logic                  bit_val;
	logic [7:0]            b0, b1, b2, b3, b4;
	logic [7:0]            csum;
	logic [14:0]           mag;
	logic [15:0]           temp;

	// Saturating tick counter
	assign cnt_inc = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + CNT_W'(1);
	assign idx_inc = idx_q + IDX_W'(1);

	// Awaited level and timeout of the current wait phase
	assign want  = !(phase_q == PH_RLOW || phase_q == PH_BLOW);
	assign limit = (phase_q == PH_REL) ? cfg.release_timeout :
	               (phase_q == PH_RLOW || phase_q == PH_RHIGH) ? cfg.response_timeout :
	               cfg.bit_timeout;
	assign bit_val = (cnt_q >= {8'd0, cfg.one_threshold});

	// Frame bytes after the final bit shifts in
	assign b0   = frame_d[39:32];
	assign b1   = frame_d[31:24];
	assign b2   = frame_d[23:16];
	assign b3   = frame_d[15:8];
	assign b4   = frame_d[7:0];
	assign csum = b0 + b1 + b2 + b3;
	assign mag  = {b2[6:0], b3};
	assign temp = b2[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};

	// Next state and result for this sample
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		frame_d = frame_q;
		res     = '0;
		unique case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					phase_d = PH_START;
					cnt_d   = '0;
					idx_d   = '0;
					frame_d = '0;
				end
			end
			PH_START: begin
				if (cnt_inc >= cfg.start_pulse_ticks) begin
					phase_d = PH_REL;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			PH_REL, PH_RLOW, PH_RHIGH, PH_BLOW, PH_BHIGH: begin
				if (line_level == want) begin
					// counted sample; zero limit means no timeout
					if (limit != 8'd0 && cnt_inc >= {8'd0, limit}) begin
						phase_d          = PH_IDLE;
						cnt_d            = '0;
						res.result_valid = 1'b1;
						res.status       = ST_TIMEOUT;
					end else begin
						cnt_d = cnt_inc;
					end
				end else if (phase_q == PH_BHIGH) begin
					// end of a data bit's high phase
					frame_d = {frame_q[N_BITS-2:0], bit_val};
					idx_d   = idx_inc;
					cnt_d   = '0;
					if (idx_inc >= IDX_W'(N_BITS)) begin
						phase_d          = PH_IDLE;
						res.result_valid = 1'b1;
						if (csum != b4) begin
							res.status = ST_CSUM;
						end else begin
							res.status             = ST_OK;
							res.humidity_tenths    = {b0, b1};
							res.temperature_tenths = temp;
						end
					end else begin
						phase_d = PH_BLOW;
					end
				end else begin
					cnt_d = '0;
					unique case (phase_q)
						PH_REL:   phase_d = PH_RLOW;
						PH_RLOW:  phase_d = PH_RHIGH;
						PH_RHIGH: phase_d = PH_BLOW;
						PH_BLOW:  phase_d = PH_BHIGH;
						default:  phase_d = PH_IDLE;
					endcase
				end
			end
			default: begin
				phase_d = PH_IDLE;
				cnt_d   = '0;
			end
		endcase
		res.drive_low = (phase_d == PH_START);
		res.busy_res  = (phase_d != PH_IDLE);
	end

	// State update on each stepped sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			frame_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			frame_q <= frame_d;
		end
	end

endmodule

@@ design/single_wire_humidity_sensor_reader.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader
// An input transfer passes the input register, then the result register.
// Throughput: one sample per cycle while m_axis_tready keeps the result
// register draining, set by the single-step sequencer update.
// Reset: arst_n clears the sequencer to idle, loads register defaults and
// empties both pipeline registers; no clearing pass.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader (
	input  logic                             clk,
	input  logic                             arst_n,
	// sample stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [swhs_pkg::IN_W-1:0]        s_axis_tdata,  // [0] start_req, [1] line_level
	// result stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] drive_low, [1] busy_res, [2] result_valid, [4:3] status,
	// [20:5] humidity_tenths, [36:21] temperature_tenths, [39:37] zero
	output logic [swhs_pkg::OUT_W-1:0]       m_axis_tdata,
	// configuration writes
	input  logic                             cfg_we,
	input  logic [swhs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [swhs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import swhs_pkg::*;

	cfg_t    cfg;
	result_t res;
	logic    valid_s1;
	logic    req_s1;
	logic    line_s1;
	logic    advance;
	logic    out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	swhs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// s1 item moves on when the result register is free or being drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	swhs_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.start_req  (req_s1),
		.line_level (line_s1),
		.cfg        (cfg),
		.res        (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1  <= s_axis_tdata[0];
			line_s1 <= s_axis_tdata[1];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {3'b000, res.temperature_tenths, res.humidity_tenths,
			               res.status, res.result_valid, res.busy_res, res.drive_low};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

@@ tb/tb_single_wire_humidity_sensor_reader.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_single_wire_humidity_sensor_reader
// Self-checking bench for the single-wire humidity sensor reader. An initial
// block queues line samples that build sensor exchanges: well-formed frames,
// forced timeouts in every wait phase, bad checksums and some free noise. Each
// register setting is loaded while the block is idle. A clocked driver feeds
// the samples with random gaps. A shadow sequencer predicts the report for
// every accepted sample. A clocked monitor with random back-pressure checks
// each report field by field.
// ----------------------------------------------------------------------------
module tb_single_wire_humidity_sensor_reader;
	import swhs_pkg::*;

	localparam int unsigned LATENCY  = 2;
	localparam longint unsigned WATCHDOG = 64'd3_000_000;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	// where an exchange is cut short by holding a level too long
	typedef enum logic [2:0] {
		BRK_NONE,
		BRK_REL,
		BRK_RLOW,
		BRK_RHIGH,
		BRK_BLOW,
		BRK_BHIGH
	} fault_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow sequencer state and register copy
	phase_t      ph = PH_IDLE;
	logic [15:0] tcnt = '0;
	logic [5:0]  bidx = '0;
	logic [39:0] frame_sr = '0;
	cfg_t        regs = {START_PULSE_RST, RELEASE_TMO_RST, RESPONSE_TMO_RST,
		BIT_TMO_RST, ONE_THRESHOLD_RST};

	logic [1:0]      line_samples[$];   // {line_level, start_req}
	result_t         tick_reports[$];
	int unsigned     pushed = 0;
	int              errors = 0;
	int unsigned     idle_pct = 27;
	longint unsigned cycles = 0;

	single_wire_humidity_sensor_reader DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 64'd1;
	end

	function automatic logic [15:0] sat_up(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// One microsecond tick of the sensor exchange
	task automatic advance_exchange(input logic req, input logic line, output result_t r);
		logic        want;
		logic        fail;
		logic        bitv;
		logic [7:0]  limit;
		logic [7:0]  b0, b1, b2, b3, b4, sum;
		logic [15:0] tw, mag;
		r = '0;
		fail = 1'b0;
		if (ph == PH_IDLE) begin
			if (req) begin
				ph = PH_START;
				tcnt = '0;
				bidx = '0;
				frame_sr = '0;
			end
		end else if (ph == PH_START) begin
			tcnt = sat_up(tcnt);
			if (tcnt >= regs.start_pulse_ticks) begin
				ph = PH_REL;
				tcnt = '0;
			end
		end else begin
			want = (ph == PH_RLOW || ph == PH_BLOW) ? 1'b0 : 1'b1;
			if (ph == PH_REL)
				limit = regs.release_timeout;
			else if (ph == PH_RLOW || ph == PH_RHIGH)
				limit = regs.response_timeout;
			else
				limit = regs.bit_timeout;
			if (line == want) begin
				tcnt = sat_up(tcnt);
				if (limit != 8'd0 && tcnt >= {8'd0, limit})
					fail = 1'b1;
			end else if (ph == PH_BHIGH) begin
				// bit ends: decide it by its high time
				bitv = (tcnt >= {8'd0, regs.one_threshold});
				frame_sr = {frame_sr[38:0], bitv};
				bidx = bidx + 6'd1;
				tcnt = '0;
				if (bidx >= 6'(N_BITS)) begin
					{b0, b1, b2, b3, b4} = frame_sr;
					sum = b0 + b1 + b2 + b3;
					r.result_valid = 1'b1;
					ph = PH_IDLE;
					if (sum != b4) begin
						r.status = ST_CSUM;
					end else begin
						tw = {b2, b3};
						mag = {1'b0, tw[14:0]};
						r.status = ST_OK;
						r.humidity_tenths = {b0, b1};
						r.temperature_tenths = tw[15] ? 16'd0 - mag : mag;
					end
				end else begin
					ph = PH_BLOW;
				end
			end else begin
				tcnt = '0;
				case (ph)
					PH_REL:   ph = PH_RLOW;
					PH_RLOW:  ph = PH_RHIGH;
					PH_RHIGH: ph = PH_BLOW;
					PH_BLOW:  ph = PH_BHIGH;
					default:  ph = PH_IDLE;
				endcase
			end
			if (fail) begin
				r.result_valid = 1'b1;
				r.status = ST_TIMEOUT;
				ph = PH_IDLE;
				tcnt = '0;
			end
		end
		r.drive_low = (ph == PH_START);
		r.busy_res = (ph != PH_IDLE);
	endtask

	// Driver: predict on each transfer, then offer the next sample
	always @(posedge clk) begin
		result_t r;
		if (s_tvalid && s_tready) begin
			advance_exchange(s_tdata[0], s_tdata[1], r);
			tick_reports.push_back(r);
		end
		if (!s_tvalid || s_tready) begin
			if (line_samples.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				s_tdata <= {{(IN_W - 2){1'b0}}, line_samples.pop_front()};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic flag(input string what, input logic [15:0] want_v, input logic [15:0] got_v);
		errors++;
		if (errors <= 10)
			$display("%0t %s: expected %h, got %h", $time, what, want_v, got_v);
	endtask

	// Monitor: check each result transfer against the oldest prediction
	always @(posedge clk) begin
		result_t e;
		if (m_tvalid && m_tready) begin
			if (tick_reports.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t result with nothing pending: %h", $time, m_tdata);
			end else begin
				e = tick_reports.pop_front();
				if (m_tdata[0] != e.drive_low)
					flag("drive_low", 16'(e.drive_low), 16'(m_tdata[0]));
				if (m_tdata[1] != e.busy_res)
					flag("busy_res", 16'(e.busy_res), 16'(m_tdata[1]));
				if (m_tdata[2] != e.result_valid)
					flag("result_valid", 16'(e.result_valid), 16'(m_tdata[2]));
				if (m_tdata[4:3] != e.status)
					flag("status", 16'(e.status), 16'(m_tdata[4:3]));
				if (m_tdata[20:5] != e.humidity_tenths)
					flag("humidity_tenths", e.humidity_tenths, m_tdata[20:5]);
				if (m_tdata[36:21] != e.temperature_tenths)
					flag("temperature_tenths", e.temperature_tenths, m_tdata[36:21]);
			end
		end
		m_tready <= ($urandom_range(0, 99) >= idle_pct);
	end

	task automatic push_sample(input logic req, input logic line);
		line_samples.push_back({line, req});
		pushed++;
	endtask

	// n samples at one level, requests random (ignored while busy)
	task automatic push_run(input logic line, input int unsigned n);
		repeat (n) push_sample(1'($urandom_range(0, 1)), line);
	endtask

	// counted ticks for a phase that must not time out; zero limit means none
	function automatic int unsigned pick_len(input int unsigned limit, input int unsigned cap);
		int unsigned hi;
		hi = (limit == 0) ? 40 : limit - 1;
		if ($urandom_range(0, 19) == 0)
			return hi;
		return $urandom_range(0, (hi < cap) ? hi : cap);
	endfunction

	// counted high ticks that encode one bit under the current threshold
	function automatic int unsigned bit_len(input logic v);
		int unsigned hi, thr, top;
		hi = (regs.bit_timeout == 0) ? 40 : 32'(regs.bit_timeout) - 1;
		thr = 32'(regs.one_threshold);
		if (v && thr <= hi) begin
			if ($urandom_range(0, 19) == 0)
				return hi;
			return $urandom_range(thr, (thr + 3 < hi) ? thr + 3 : hi);
		end
		if (thr == 0)
			return 0;
		top = (thr - 1 < hi) ? thr - 1 : hi;
		if ($urandom_range(0, 19) == 0)
			return top;
		return $urandom_range(0, (top < 3) ? top : 3);
	endfunction

	// Frame contents: corner values first, then random with some bad sums
	function automatic logic [39:0] make_frame(input int unsigned n);
		logic [15:0] hum, tw;
		logic [7:0]  sum;
		case (n)
			0:       {hum, tw} = {16'hFFFF, 16'h7FFF};
			1:       {hum, tw} = {16'h0000, 16'h8000};   // negative zero
			2:       {hum, tw} = {16'h0000, 16'hFFFF};
			3:       {hum, tw} = 32'h0;
			4:       {hum, tw} = {16'h03E8, 16'h8001};
			default: {hum, tw} = $urandom;
		endcase
		sum = hum[15:8] + hum[7:0] + tw[15:8] + tw[7:0];
		if (n > 4 && $urandom_range(0, 4) == 0)
			sum = sum ^ 8'($urandom_range(1, 255));
		return {hum, tw, sum};
	endfunction

	// One exchange as line samples; stretch overrides the first bit's high time
	task automatic push_exchange(input logic [39:0] frame, input fault_t fault,
		input int unsigned stretch);
		int unsigned k, span, i;
		k = $urandom_range(0, N_BITS - 1);
		push_sample(1'b1, 1'($urandom_range(0, 1)));
		span = (regs.start_pulse_ticks == 0) ? 1 : 32'(regs.start_pulse_ticks);
		repeat (span) push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		if (fault == BRK_REL) begin
			push_run(1'b1, 32'(regs.release_timeout));
			return;
		end
		push_run(1'b1, pick_len(32'(regs.release_timeout), 3));
		if (fault == BRK_RLOW) begin
			push_run(1'b0, 1 + 32'(regs.response_timeout));
			return;
		end
		push_run(1'b0, 1 + pick_len(32'(regs.response_timeout), 3));
		if (fault == BRK_RHIGH) begin
			push_run(1'b1, 1 + 32'(regs.response_timeout));
			return;
		end
		push_run(1'b1, 1 + pick_len(32'(regs.response_timeout), 3));
		for (i = 0; i < N_BITS; i++) begin
			if (fault == BRK_BLOW && i == k) begin
				push_run(1'b0, 1 + 32'(regs.bit_timeout));
				return;
			end
			push_run(1'b0, 1 + pick_len(32'(regs.bit_timeout), 2));
			if (fault == BRK_BHIGH && i == k) begin
				push_run(1'b1, 1 + 32'(regs.bit_timeout));
				return;
			end
			push_run(1'b1, 1 + ((stretch != 0 && i == 0) ? stretch : bit_len(frame[39 - i])));
		end
		// low that ends the last bit, then a short idle gap
		push_sample(1'($urandom_range(0, 1)), 1'b0);
		repeat ($urandom_range(0, 3)) push_sample(1'b0, 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_sent();
		while (line_samples.size() != 0 || s_tvalid)
			@(negedge clk);
	endtask

	// Bring the sequencer back to idle and let every result drain
	task automatic settle();
		wait_sent();
		while (ph != PH_IDLE) begin
			push_sample(1'b0, ph == PH_RLOW || ph == PH_BLOW);
			wait_sent();
		end
		while (tick_reports.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 1) @(negedge clk);
	endtask

	task automatic run_phase(input int unsigned budget, input logic faults, input logic noise);
		int unsigned mark, n;
		fault_t      f;
		mark = pushed;
		n = 0;
		while (pushed - mark < budget) begin
			f = BRK_NONE;
			if (faults && $urandom_range(0, 5) == 0) begin
				f = fault_t'($urandom_range(1, 5));
				if ((f == BRK_REL && regs.release_timeout == 0) ||
					((f == BRK_RLOW || f == BRK_RHIGH) && regs.response_timeout == 0) ||
					((f == BRK_BLOW || f == BRK_BHIGH) && regs.bit_timeout == 0))
					f = BRK_NONE;
			end
			push_exchange(make_frame(n), f, 0);
			n++;
		end
		if (noise)
			repeat (60) push_sample($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
		settle();
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_START_PULSE:   regs.start_pulse_ticks = val;
			CFG_RELEASE_TMO:   regs.release_timeout = val[7:0];
			CFG_RESPONSE_TMO:  regs.response_timeout = val[7:0];
			CFG_BIT_TMO:       regs.bit_timeout = val[7:0];
			CFG_ONE_THRESHOLD: regs.one_threshold = val[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// 8-bit registers get junk in the upper data byte
	task automatic set_all(input logic [15:0] pulse, input logic [7:0] rel,
		input logic [7:0] resp, input logic [7:0] bitt, input logic [7:0] thr);
		logic [7:0] junk;
		junk = 8'($urandom);
		set_reg(CFG_START_PULSE, pulse);
		set_reg(CFG_RELEASE_TMO, {junk, rel});
		set_reg(CFG_RESPONSE_TMO, {~junk, resp});
		set_reg(CFG_BIT_TMO, {junk, bitt});
		set_reg(CFG_ONE_THRESHOLD, {~junk, thr});
	endtask

	// Watchdog
	initial begin
		while (cycles < WATCHDOG)
			@(posedge clk);
		$display("tb_single_wire_humidity_sensor_reader: errors");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle samples at reset defaults
		push_sample(1'b0, 1'b0);
		push_sample(1'b0, 1'b1);
		settle();

		// short pulse, other timeouts at defaults; cut off in the response high
		set_reg(CFG_START_PULSE, 16'd4);
		push_exchange(make_frame(0), BRK_RHIGH, 0);
		settle();

		// zero start pulse, short timeouts
		set_all(16'd0, 8'd3, 8'd4, 8'd6, 8'd2);
		run_phase(350, 1'b1, 1'b0);

		// all registers set to one
		set_all(16'd1, 8'd1, 8'd1, 8'd1, 8'd1);
		run_phase(150, 1'b1, 1'b0);

		// all 8-bit registers at their maximum; cut off in the response high
		set_all(16'd5, 8'd255, 8'd255, 8'd255, 8'd255);
		push_exchange(make_frame(1), BRK_RHIGH, 0);
		settle();

		// no limits; first bit held long
		set_all(16'd2, 8'd0, 8'd0, 8'd0, 8'd3);
		push_exchange(make_frame(0), BRK_NONE, 45);
		settle();

		// no idling from here on; mid values, random noise at the end
		idle_pct = 0;
		set_reg(CFG_SPARE, 16'($urandom));
		set_all(16'd3, 8'd10, 8'd12, 8'd8, 8'd4);
		run_phase(250, 1'b1, 1'b1);

		errors += tick_reports.size();
		if (errors == 0)
			$display("tb_single_wire_humidity_sensor_reader: clean");
		else
			$display("tb_single_wire_humidity_sensor_reader: errors");
		$finish;
	end

endmodule

@@ files.f @@
design/swhs_pkg.sv
design/swhs_cfg.sv
design/swhs_fsm.sv
design/single_wire_humidity_sensor_reader.sv
tb/tb_single_wire_humidity_sensor_reader.sv
